@@ rtl/core/pes_pkg.sv @@
// shared types, codes and constants of the periodic event scheduler
package pes_pkg;

   localparam int MAX_EVENTS_DEF = 16;

   localparam int OP_W    = 2;
   localparam int INDEX_W = 4;
   localparam int PER_W   = 15;
   localparam int PH_W    = 16;
   localparam int TIME_W  = 32;
   localparam int MASK_W  = 16;
   localparam int COUNT_W = 5;
   localparam int CSR_W   = 1;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_FORCE = 2'd2;

   localparam logic [CSR_W-1:0] CSR_EVENT_COUNT = 1'b0;
   localparam logic [CSR_W-1:0] CSR_ENABLE_MASK = 1'b1;

   localparam logic [TIME_W-1:0] DUE_NONE     = 32'hFFFF_FFFF;
   localparam logic [MASK_W-1:0] EVENT_ONE    = 16'h0001;
   localparam logic [MASK_W-1:0] ENABLE_RESET = 16'hFFFF;

   typedef struct packed {
      logic latch_req;
      logic take_forced;
      logic scan_init;
      logic entry_next;
      logic div_start;
      logic mul_load;
      logic cand_update;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic op_tick;
      logic forced_nz;
      logic armed;
      logic scan_end;
      logic entry_skip;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/periodic_event_scheduler.sv @@
// periodic event scheduler top level: controller plus datapath
// load, force, armed tick or forced tick: the request passes the decode and done states and the
//   response is registered; a tick that rebuilds the schedule scans the entries, skipping disabled
//   or zero-period ones, and runs the serial divider once per active entry
// one request at a time: the next is taken once the controller is back in idle after the response
// reset: synchronous, clears control state, config to defaults, due time all ones, disarmed
module periodic_event_scheduler #(
   parameter int MAX_EVENTS = pes_pkg::MAX_EVENTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pes_pkg::OP_W-1:0]        req_operation,
   input  logic [pes_pkg::INDEX_W-1:0]     req_entry_index,
   input  logic [pes_pkg::PER_W-1:0]       req_period,
   input  logic signed [pes_pkg::PH_W-1:0] req_phase,
   input  logic [pes_pkg::TIME_W-1:0]      req_now_seconds,
   input  logic [pes_pkg::MASK_W-1:0]      req_force_mask,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_fired,
   output logic [pes_pkg::MASK_W-1:0]      rsp_event_mask,
   output logic [pes_pkg::TIME_W-1:0]      rsp_due_time,
   output logic [pes_pkg::TIME_W-1:0]      rsp_wait_left,
   input  logic                            csr_we,
   input  logic [pes_pkg::CSR_W-1:0]       csr_index,
   input  logic [pes_pkg::MASK_W-1:0]      csr_wdata
);
   import pes_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       idle;

   assign req_stall = reset || !idle;

   pes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .idle      (idle)
   );

   pes_dp #(
      .MAX_EVENTS (MAX_EVENTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_entry_index (req_entry_index),
      .req_period      (req_period),
      .req_phase       (req_phase),
      .req_now_seconds (req_now_seconds),
      .req_force_mask  (req_force_mask),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fired       (rsp_fired),
      .rsp_event_mask  (rsp_event_mask),
      .rsp_due_time    (rsp_due_time),
      .rsp_wait_left   (rsp_wait_left)
   );

endmodule

@@ rtl/core/pes_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module pes_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pes_pkg::TIME_W-1:0]   dividend,
   input  logic [pes_pkg::PER_W-1:0]    divisor,
   output logic                         done,
   output logic [pes_pkg::TIME_W-1:0]   quotient
);
   import pes_pkg::*;

   localparam int CNT_W = $clog2(TIME_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TIME_W-1:0]   quo_ff, quo_in;
   logic [PER_W-1:0]    rem_ff, rem_in;
   logic [PER_W-1:0]    dvs_ff, dvs_in;
   logic [PER_W:0]      rem_sh;
   logic [PER_W:0]      rem_sub;
   logic                step_ge;

   assign rem_sh  = {rem_ff, quo_ff[TIME_W-1]};
   assign step_ge = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         // dividend bits shift out of quo while quotient bits shift in
         quo_in   = {quo_ff[TIME_W-2:0], step_ge};
         rem_in   = step_ge ? rem_sub[PER_W-1:0] : rem_sh[PER_W-1:0];
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/pes_ctrl.sv @@
// sequencing state machine of the scheduler
module pes_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  pes_pkg::status_type  status,
   output pes_pkg::cmd_type     cmd,
   output logic                 idle
);
   import pes_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_CAND   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.op_tick && status.forced_nz) begin
               cmd.take_forced = 1'b1;
               state_in        = ST_DONE;
            end else if (status.op_tick && !status.armed) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (status.scan_end) begin
               state_in = ST_DONE;
            end else if (status.entry_skip) begin
               cmd.entry_next = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.mul_load = 1'b1;
               state_in     = ST_CAND;
            end
         end
         ST_CAND: begin
            cmd.cand_update = 1'b1;
            cmd.entry_next  = 1'b1;
            state_in        = ST_SCAN;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

@@ rtl/core/pes_dp.sv @@
// scheduler datapath: schedule table, config, due-time search and response register
module pes_dp #(
   parameter int MAX_EVENTS = pes_pkg::MAX_EVENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pes_pkg::cmd_type              cmd,
   output pes_pkg::status_type           status,
   input  logic [pes_pkg::OP_W-1:0]      req_operation,
   input  logic [pes_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [pes_pkg::PER_W-1:0]     req_period,
   input  logic signed [pes_pkg::PH_W-1:0] req_phase,
   input  logic [pes_pkg::TIME_W-1:0]    req_now_seconds,
   input  logic [pes_pkg::MASK_W-1:0]    req_force_mask,
   input  logic                          csr_we,
   input  logic [pes_pkg::CSR_W-1:0]     csr_index,
   input  logic [pes_pkg::MASK_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_fired,
   output logic [pes_pkg::MASK_W-1:0]    rsp_event_mask,
   output logic [pes_pkg::TIME_W-1:0]    rsp_due_time,
   output logic [pes_pkg::TIME_W-1:0]    rsp_wait_left
);
   import pes_pkg::*;

   localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
   localparam int CNT_W = $clog2(MAX_EVENTS + 1);
   localparam int PROD_W = TIME_W + PER_W;

   // latched request
   logic [OP_W-1:0]     op_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [PER_W-1:0]    per_ff;
   logic [PH_W-1:0]     ph_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [MASK_W-1:0]   fmask_ff;

   logic [PER_W-1:0]    interval_ff [MAX_EVENTS];
   logic [PH_W-1:0]     offset_ff [MAX_EVENTS];

   logic [COUNT_W-1:0]  event_count_ff, event_count_in;
   logic [MASK_W-1:0]   enable_mask_ff, enable_mask_in;
   logic [TIME_W-1:0]   next_due_ff, next_due_in;
   logic [MASK_W-1:0]   pending_ff, pending_in;
   logic [MASK_W-1:0]   forced_ff, forced_in;
   logic                armed_ff, armed_in;
   logic                forced_hit_ff, forced_hit_in;
   logic [CNT_W-1:0]    entry_ff, entry_in;
   logic [TIME_W-1:0]   prod_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_fired_ff;
   logic [MASK_W-1:0]   rsp_bits_ff;
   logic [TIME_W-1:0]   rsp_due_ff;
   logic [TIME_W-1:0]   rsp_wait_ff;

   logic [IDX_W-1:0]    entry_sel;
   logic [PER_W-1:0]    cur_per;
   logic [TIME_W-1:0]   cur_off;
   logic [MASK_W-1:0]   cur_bit;
   logic [TIME_W-1:0]   cand;
   logic [TIME_W-1:0]   quotient;
   logic [TIME_W-1:0]   q_inc;
   logic [PROD_W-1:0]   prod_full;
   logic                div_done;
   logic                is_tick;
   logic                due_reached;
   logic                tbl_we;
   logic                out_free;

   assign entry_sel = entry_ff[IDX_W-1:0];
   assign cur_per   = interval_ff[entry_sel];
   assign cur_off   = {{(TIME_W-PH_W){offset_ff[entry_sel][PH_W-1]}}, offset_ff[entry_sel]};
   assign cur_bit   = EVENT_ONE << entry_sel;
   assign cand      = prod_ff + cur_off;
   assign q_inc     = quotient + TIME_W'(1);
   assign prod_full = PROD_W'(q_inc) * PROD_W'(cur_per);

   pes_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (now_ff - cur_off),
      .divisor  (cur_per),
      .done     (div_done),
      .quotient (quotient)
   );

   assign is_tick     = (op_ff == OP_TICK);
   assign due_reached = (now_ff >= next_due_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign tbl_we      = cmd.finish && (op_ff == OP_LOAD)
                        && (32'(idx_ff) < MAX_EVENTS);

   always_comb begin
      status            = '0;
      status.op_tick    = is_tick;
      status.forced_nz  = (forced_ff != '0);
      status.armed      = armed_ff;
      status.scan_end   = (entry_ff == CNT_W'(MAX_EVENTS))
                          || (COUNT_W'(entry_ff) >= event_count_ff);
      status.entry_skip = !enable_mask_ff[entry_sel] || (cur_per == '0);
      status.div_done   = div_done;
      status.out_free   = out_free;
   end

   always_comb begin
      event_count_in = event_count_ff;
      enable_mask_in = enable_mask_ff;
      next_due_in    = next_due_ff;
      pending_in     = pending_ff;
      forced_in      = forced_ff;
      armed_in       = armed_ff;
      forced_hit_in  = forced_hit_ff;
      entry_in       = entry_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (cmd.latch_req) begin
         forced_hit_in = 1'b0;
      end
      if (cmd.take_forced) begin
         pending_in    = forced_ff;
         forced_in     = '0;
         forced_hit_in = 1'b1;
      end
      if (cmd.scan_init) begin
         next_due_in = DUE_NONE;
         pending_in  = '0;
         entry_in    = '0;
      end
      if (cmd.cand_update) begin
         if (cand < next_due_ff) begin
            next_due_in = cand;
            pending_in  = cur_bit;
         end else if (cand == next_due_ff) begin
            pending_in = pending_ff | cur_bit;
         end
      end
      if (cmd.entry_next) begin
         entry_in = entry_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         case (op_ff)
            OP_LOAD: begin
               armed_in = 1'b0;
            end
            OP_FORCE: begin
               forced_in = fmask_ff;
               armed_in  = 1'b0;
            end
            OP_TICK: begin
               // stays armed until the due time is reached or a forced tick hits
               armed_in = !forced_hit_ff && !due_reached;
            end
            default: begin
               armed_in = armed_ff;
            end
         endcase
      end
      if (csr_we) begin
         armed_in = 1'b0;
         unique case (csr_index)
            CSR_EVENT_COUNT: event_count_in = csr_wdata[COUNT_W-1:0];
            CSR_ENABLE_MASK: enable_mask_in = csr_wdata;
            default:         enable_mask_in = enable_mask_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_count_ff <= '0;
         enable_mask_ff <= ENABLE_RESET;
         next_due_ff    <= DUE_NONE;
         pending_ff     <= '0;
         forced_ff      <= '0;
         armed_ff       <= 1'b0;
         forced_hit_ff  <= 1'b0;
         entry_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         event_count_ff <= event_count_in;
         enable_mask_ff <= enable_mask_in;
         next_due_ff    <= next_due_in;
         pending_ff     <= pending_in;
         forced_ff      <= forced_in;
         armed_ff       <= armed_in;
         forced_hit_ff  <= forced_hit_in;
         entry_ff       <= entry_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= req_operation;
         idx_ff   <= req_entry_index;
         per_ff   <= req_period;
         ph_ff    <= req_phase;
         now_ff   <= req_now_seconds;
         fmask_ff <= req_force_mask;
      end
      if (tbl_we) begin
         interval_ff[idx_ff[IDX_W-1:0]] <= per_ff;
         offset_ff[idx_ff[IDX_W-1:0]]   <= ph_ff;
      end
      if (cmd.mul_load) begin
         prod_ff <= prod_full[TIME_W-1:0];
      end
      if (cmd.finish) begin
         rsp_fired_ff <= is_tick && (forced_hit_ff || due_reached);
         rsp_bits_ff  <= is_tick ? pending_ff : '0;
         rsp_due_ff   <= next_due_ff;
         rsp_wait_ff  <= is_tick ? (next_due_ff - now_ff) : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_event_mask = rsp_bits_ff;
   assign rsp_due_time   = rsp_due_ff;
   assign rsp_wait_left  = rsp_wait_ff;

endmodule

@@ rtl/core/pes_checker.sv @@
// port-level checks of the periodic event scheduler, bound to the top level
module pes_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_fired,
   input logic [pes_pkg::MASK_W-1:0]      rsp_event_mask,
   input logic [pes_pkg::TIME_W-1:0]      rsp_due_time,
   input logic [pes_pkg::TIME_W-1:0]      rsp_wait_left
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fired)
      && $stable(rsp_event_mask) && $stable(rsp_due_time) && $stable(rsp_wait_left))
      else $error("stalled response changed");

   // one request in flight: the block is busy right after taking one
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   // a new response only comes out of a request in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in progress");

   // a response with nothing fired and no wait left is a non-tick reply
   a_idle_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired && (rsp_wait_left == '0) |-> (rsp_event_mask == '0))
      else $error("non-tick response carries event bits");

endmodule

bind periodic_event_scheduler pes_checker u_pes_checker (.*);
